/* rtl/rdcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcd_pkg
// shared constants, command codes and controller/datapath interface structs
// for the ramped decimal counter display core
// ----------------------------------------------------------------------------
package rdcd_pkg;

  localparam int VALUE_BITS = 63;
  localparam int W_VALUE    = 63;
  localparam int W_COUNT    = 16;
  localparam int W_CMD      = 2;
  localparam int NUM_DIGITS = 19;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int W_LOW      = 64;
  localparam int W_HIGH     = 12;
  localparam int DCNT_W     = 5;
  localparam int REM_W      = W_COUNT;
  localparam int ITER_W     = $clog2(VALUE_BITS);

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 152;

  localparam int OUT_LOW_LSB  = W_VALUE;
  localparam int OUT_HIGH_LSB = OUT_LOW_LSB + W_LOW;
  localparam int OUT_DCNT_LSB = OUT_HIGH_LSB + W_HIGH;
  localparam int OUT_BUSY_BIT = OUT_DCNT_LSB + DCNT_W;

  typedef enum logic [W_CMD-1:0] {
    CMD_SET  = 2'd0,
    CMD_RAMP = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic div_step;
    logic div_finish;
    logic conv_load;
    logic conv_step;
    logic count;
    logic out_load;
  } rdcd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic iter_last;
    logic out_free;
  } rdcd_sts_t;

endpackage

/* rtl/rdcd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcd_ctrl
// sequencer: accept a word, run the command, divide if needed, convert to
// bcd, count digits and hand the result to the output register
// ----------------------------------------------------------------------------
module rdcd_ctrl
  import rdcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  rdcd_sts_t sts_i,
  output rdcd_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_EXEC   = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_DIVEND = 8'b0000_1000,
    ST_CLOAD  = 8'b0001_0000,
    ST_DABBLE = 8'b0010_0000,
    ST_COUNT  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_o.latch = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_nxt  = sts_i.need_div ? ST_DIV : ST_CLOAD;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.iter_last) begin
          state_nxt = ST_DIVEND;
        end
      end
      ST_DIVEND: begin
        cmd_o.div_finish = 1'b1;
        state_nxt        = ST_CLOAD;
      end
      ST_CLOAD: begin
        cmd_o.conv_load = 1'b1;
        state_nxt       = ST_DABBLE;
      end
      ST_DABBLE: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.iter_last) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd_o.count = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rdcd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcd_datapath
// counter state, restoring divider for the ramp step, double-dabble bcd
// converter, digit counter and output register
// ----------------------------------------------------------------------------
module rdcd_datapath
  import rdcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  rdcd_cmd_t           cmd_i,
  output rdcd_sts_t           sts_o,
  input  logic [W_CMD-1:0]    in_cmd,
  input  logic [W_VALUE-1:0]  in_value,
  input  logic [W_COUNT-1:0]  in_step_count,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [W_VALUE-1:0]  out_shown_value,
  output logic [W_LOW-1:0]    out_digits_low,
  output logic [W_HIGH-1:0]   out_digits_high,
  output logic [DCNT_W-1:0]   out_digit_count,
  output logic                out_busy_res
);

  // control state
  logic [VALUE_BITS-1:0] shown_r, shown_nxt;
  logic [VALUE_BITS-1:0] target_r, target_nxt;
  logic [VALUE_BITS-1:0] step_r, step_nxt;
  logic                  ramping_r, ramping_nxt;
  logic                  up_r, up_nxt;
  logic [ITER_W-1:0]     iter_r, iter_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // payload
  cmd_code_t             lat_cmd_r, lat_cmd_nxt;
  logic [VALUE_BITS-1:0] lat_val_r, lat_val_nxt;
  logic [W_COUNT-1:0]    lat_cnt_r, lat_cnt_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [W_COUNT-1:0]    divisor_r, divisor_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic [W_VALUE-1:0]    o_shown_r, o_shown_nxt;
  logic [BCD_W-1:0]      o_bcd_r, o_bcd_nxt;
  logic [DCNT_W-1:0]     o_dcnt_r, o_dcnt_nxt;
  logic                  o_busy_r, o_busy_nxt;

  logic [VALUE_BITS-1:0] eff_shown;
  logic                  up_dir;
  logic [VALUE_BITS-1:0] ramp_dist;
  logic [VALUE_BITS:0]   sum;
  logic [REM_W:0]        trial;
  logic [REM_W:0]        trial_diff;
  logic                  trial_ge;
  logic [BCD_W-1:0]      bcd_adj;
  logic [DCNT_W-1:0]     dcnt_calc;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(VALUE_BITS - 1);

  assign eff_shown  = ramping_r ? target_r : shown_r;
  assign up_dir     = lat_val_r > eff_shown;
  assign ramp_dist  = up_dir ? (lat_val_r - eff_shown) : (eff_shown - lat_val_r);
  assign sum        = {1'b0, shown_r} + {1'b0, step_r};
  assign trial      = {rem_r, quo_r[VALUE_BITS-1]};
  assign trial_diff = trial - {1'b0, divisor_r};
  assign trial_ge   = trial >= {1'b0, divisor_r};

  assign sts_o.need_div  = (lat_cmd_r == CMD_RAMP) && (lat_val_r != target_r);
  assign sts_o.iter_last = (iter_r == '0);
  assign sts_o.out_free  = !out_valid_r || out_tready;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    dcnt_calc = DCNT_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        dcnt_calc = DCNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    shown_nxt     = shown_r;
    target_nxt    = target_r;
    step_nxt      = step_r;
    ramping_nxt   = ramping_r;
    up_nxt        = up_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r;
    lat_cmd_nxt   = lat_cmd_r;
    lat_val_nxt   = lat_val_r;
    lat_cnt_nxt   = lat_cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    divisor_nxt   = divisor_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    dcnt_nxt      = dcnt_r;
    o_shown_nxt   = o_shown_r;
    o_bcd_nxt     = o_bcd_r;
    o_dcnt_nxt    = o_dcnt_r;
    o_busy_nxt    = o_busy_r;

    if (cmd_i.latch) begin
      lat_cmd_nxt = cmd_code_t'(in_cmd);
      lat_val_nxt = VALUE_BITS'(in_value);
      lat_cnt_nxt = in_step_count;
    end

    if (cmd_i.exec) begin
      unique case (lat_cmd_r)
        CMD_SET: begin
          shown_nxt   = lat_val_r;
          target_nxt  = lat_val_r;
          ramping_nxt = 1'b0;
        end
        CMD_RAMP: begin
          if (sts_o.need_div) begin
            shown_nxt   = eff_shown;
            target_nxt  = lat_val_r;
            ramping_nxt = 1'b1;
            up_nxt      = up_dir;
            quo_nxt     = ramp_dist;
            rem_nxt     = '0;
            divisor_nxt = (lat_cnt_r == '0) ? W_COUNT'(1) : lat_cnt_r;
            iter_nxt    = ITER_LAST;
          end
        end
        CMD_TICK: begin
          if (ramping_r) begin
            if (up_r) begin
              if (sum >= {1'b0, target_r}) begin
                shown_nxt   = target_r;
                ramping_nxt = 1'b0;
              end else begin
                shown_nxt = sum[VALUE_BITS-1:0];
              end
            end else begin
              if ((shown_r <= target_r) || ((shown_r - target_r) <= step_r)) begin
                shown_nxt   = target_r;
                ramping_nxt = 1'b0;
              end else begin
                shown_nxt = shown_r - step_r;
              end
            end
          end
        end
        CMD_NOP: begin
        end
      endcase
    end

    if (cmd_i.div_step) begin
      rem_nxt  = trial_ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_nxt  = {quo_r[VALUE_BITS-2:0], trial_ge};
      iter_nxt = iter_r - ITER_W'(1);
    end

    if (cmd_i.div_finish) begin
      step_nxt = quo_r + VALUE_BITS'(rem_r != '0);
    end

    if (cmd_i.conv_load) begin
      bin_nxt  = shown_r;
      bcd_nxt  = '0;
      iter_nxt = ITER_LAST;
    end

    if (cmd_i.conv_step) begin
      bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
      bin_nxt  = {bin_r[VALUE_BITS-2:0], 1'b0};
      iter_nxt = iter_r - ITER_W'(1);
    end

    if (cmd_i.count) begin
      dcnt_nxt = dcnt_calc;
    end

    if (cmd_i.out_load) begin
      out_valid_nxt = 1'b1;
      o_shown_nxt   = W_VALUE'(shown_r);
      o_bcd_nxt     = bcd_r;
      o_dcnt_nxt    = dcnt_r;
      o_busy_nxt    = ramping_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= '0;
      target_r    <= '0;
      step_r      <= '0;
      ramping_r   <= 1'b0;
      up_r        <= 1'b0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      shown_r     <= shown_nxt;
      target_r    <= target_nxt;
      step_r      <= step_nxt;
      ramping_r   <= ramping_nxt;
      up_r        <= up_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_cmd_r <= lat_cmd_nxt;
    lat_val_r <= lat_val_nxt;
    lat_cnt_r <= lat_cnt_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    dcnt_r    <= dcnt_nxt;
    o_shown_r <= o_shown_nxt;
    o_bcd_r   <= o_bcd_nxt;
    o_dcnt_r  <= o_dcnt_nxt;
    o_busy_r  <= o_busy_nxt;
  end

  assign out_tvalid      = out_valid_r;
  assign out_shown_value = o_shown_r;
  assign out_digits_low  = o_bcd_r[W_LOW-1:0];
  assign out_digits_high = o_bcd_r[BCD_W-1:W_LOW];
  assign out_digit_count = o_dcnt_r;
  assign out_busy_res    = o_busy_r;

endmodule

/* rtl/ramped_decimal_counter_display_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_decimal_counter_display_core
// ramping display counter with packed bcd output
// ----------------------------------------------------------------------------
// usage
//   input stream: in_tuser carries the command (set, ramp, tick, nop), in_tdata
//   the value and step count. every accepted word gives exactly one word on
//   the output stream: shown value, bcd digits, digit count and busy flag.
//   for set, tick and a ramp to the current target a word runs through
//   execute, bcd load, the bcd shift loop and digit count; a ramp that starts
//   a new step computation runs the step divider first. the sequencer runs one
//   word at a time, so in_tready rises again in the cycle after the result is
//   loaded. the bcd shift loop and the one-bit-per-cycle step divider both
//   have their length set by the value width.
//   the output register holds a finished word while the receiver stalls;
//   the next word is accepted and processed meanwhile and waits at the end
//   until the output register is free.
//   synchronous reset clears the shown value, target, step and ramp state
//   and empties the output register.
// ----------------------------------------------------------------------------
module ramped_decimal_counter_display_core
  import rdcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [W_CMD-1:0]       in_tuser,   // cmd
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[62:0], step_count[78:63]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // shown_value[62:0], digits_low[126:63], digits_high[138:127],
  // digit_count[143:139], busy_res[144]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  rdcd_cmd_t cmd;
  rdcd_sts_t sts;

  logic [W_VALUE-1:0] shown_value;
  logic [W_LOW-1:0]   digits_low;
  logic [W_HIGH-1:0]  digits_high;
  logic [DCNT_W-1:0]  digit_count;
  logic               busy_res;

  rdcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rdcd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_cmd          (in_tuser),
    .in_value        (in_tdata[W_VALUE-1:0]),
    .in_step_count   (in_tdata[W_VALUE +: W_COUNT]),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_shown_value (shown_value),
    .out_digits_low  (digits_low),
    .out_digits_high (digits_high),
    .out_digit_count (digit_count),
    .out_busy_res    (busy_res)
  );

  assign out_tdata = {
    {(OUT_TDATA_W - OUT_BUSY_BIT - 1){1'b0}},
    busy_res, digit_count, digits_high, digits_low, shown_value
  };

endmodule

/* rtl/rdcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcd_checker
// port-level checks for the ramped decimal counter display core
// ----------------------------------------------------------------------------
module rdcd_checker
  import rdcd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [DCNT_W-1:0] dcnt;
  assign dcnt = out_tdata[OUT_DCNT_LSB +: DCNT_W];

  // one word in flight: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // result digit count in range
  a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((dcnt >= DCNT_W'(1)) && (dcnt <= DCNT_W'(NUM_DIGITS))))
    else $error("digit count out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output word changed");

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind ramped_decimal_counter_display_core rdcd_checker u_rdcd_checker (.*);
